### hdl/otsu_pkg.sv
// Package: constants, types and state encoding of the Otsu threshold unit.
`default_nettype none

package otsu_pkg;

  // Histogram geometry
  localparam int NUM_BINS   = 256;
  localparam int COUNT_BITS = 16;
  localparam int BIN_W      = 16;
  localparam int KEEP_BITS  = (COUNT_BITS < BIN_W) ? COUNT_BITS : BIN_W;
  localparam logic [BIN_W-1:0] BIN_MASK = BIN_W'((64'(1) << KEEP_BITS) - 64'(1));
  localparam int ADDR_W     = $clog2(NUM_BINS);
  localparam int IDX_W      = $clog2(NUM_BINS + 1);
  localparam int LEVEL_W    = 8;

  // Accumulator and product widths
  localparam int PIX_W  = 24;
  localparam int WSUM_W = 32;
  localparam int DIFF_W = PIX_W + WSUM_W;
  localparam int DEN_W  = 2 * PIX_W;
  localparam int SQ_W   = 2 * DIFF_W;

  // Digit-serial multiplier geometry
  localparam int DIGIT_W    = 8;
  localparam int MUL_X_W    = SQ_W;
  localparam int MUL_Y_W    = DIFF_W;
  localparam int MUL_DIGITS = MUL_Y_W / DIGIT_W;
  localparam int MUL_CNT_W  = $clog2(MUL_DIGITS + 1);
  localparam int PROD_W     = MUL_X_W + MUL_Y_W;

  typedef struct packed {
    logic               start;
    logic [MUL_X_W-1:0] x;
    logic [MUL_Y_W-1:0] y;
  } otsu_mul_req_t;

  typedef struct packed {
    logic              busy;
    logic [PROD_W-1:0] product;
  } otsu_mul_rsp_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RD,
    ST_ACC,
    ST_PROD,
    ST_DIFF,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_LHS_GO,
    ST_LHS_WAIT,
    ST_CMP,
    ST_NEXT,
    ST_DONE
  } otsu_state_t;

endpackage

`default_nettype wire

### hdl/otsu_if.sv
// Interfaces: histogram bin channel and threshold result channel.
`default_nettype none

interface otsu_in_if;
  logic                      valid;
  logic                      ready;
  logic [otsu_pkg::BIN_W-1:0] bin_count;
  logic                      last_bin;

  modport source (output valid, output bin_count, output last_bin, input ready);
  modport sink   (input valid, input bin_count, input last_bin, output ready);
endinterface

interface otsu_out_if;
  logic                        valid;
  logic                        ready;
  logic [otsu_pkg::LEVEL_W-1:0] threshold_level;
  logic                        no_split;

  modport source (output valid, output threshold_level, output no_split, input ready);
  modport sink   (input valid, input threshold_level, input no_split, output ready);
endinterface

`default_nettype wire

### hdl/otsu_threshold_from_histogram_unit.sv
// Otsu threshold unit: bins in, one threshold level out per histogram.
// Input channel in_ch carries one histogram bin per transaction, lowest grey
// level first; last_bin marks the final bin. Bins beyond NUM_BINS are ignored,
// but last_bin still closes the histogram. Output channel out_ch carries one
// transaction per histogram: the level with the largest between-class variance
// (ties keep the lower level), or level 0 with no_split set if none is positive.
// Loading accepts one bin per cycle, written straight into the bin RAM.
// After the last bin the unit sweeps the RAM with in_ch.ready low; a bin whose
// split is empty is not scored, and a bin that is scored takes two 7-digit
// passes of the digit-serial multiplier (d*d, then d*d times the best
// denominator). The sweep ends in ST_DONE, which registers the result.
// The result sits in an output register; the next histogram may load while it
// waits. If the receiver still stalls when the following sweep ends, the unit
// holds in its final state until the output register frees.
// Reset (synchronous, active low) clears the totals, the best-level tracking
// and out_ch.valid; the bin RAM needs no clearing since only bins loaded for
// the current histogram are read.
`default_nettype none

module otsu_threshold_from_histogram_unit (
  input  logic              clk,
  input  logic              rst_n,
  otsu_in_if.sink           in_ch,
  otsu_out_if.source        out_ch
);

  otsu_pkg::otsu_state_t state_r, state_nxt;

  logic [otsu_pkg::IDX_W-1:0]   load_idx_r, load_idx_nxt;
  logic [otsu_pkg::IDX_W-1:0]   sweep_idx_r, sweep_idx_nxt;
  logic [otsu_pkg::PIX_W-1:0]   tot_pix_r, tot_pix_nxt;
  logic [otsu_pkg::WSUM_W-1:0]  tot_wsum_r, tot_wsum_nxt;
  logic [otsu_pkg::PIX_W-1:0]   run_pix_r, run_pix_nxt;
  logic [otsu_pkg::WSUM_W-1:0]  run_wsum_r, run_wsum_nxt;
  logic [otsu_pkg::DIFF_W-1:0]  a_r, a_nxt;
  logic [otsu_pkg::DIFF_W-1:0]  b_r, b_nxt;
  logic [otsu_pkg::PIX_W-1:0]   rem_pix_r, rem_pix_nxt;
  logic [otsu_pkg::DIFF_W-1:0]  d_r, d_nxt;
  logic [otsu_pkg::DEN_W-1:0]   den_r, den_nxt;
  logic [otsu_pkg::SQ_W-1:0]    d2_r, d2_nxt;
  logic [otsu_pkg::PROD_W-1:0]  rhs_r, rhs_nxt;
  logic [otsu_pkg::SQ_W-1:0]    best_d2_r, best_d2_nxt;
  logic [otsu_pkg::DEN_W-1:0]   best_den_r, best_den_nxt;
  logic [otsu_pkg::ADDR_W-1:0]  best_level_r, best_level_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [otsu_pkg::LEVEL_W-1:0] out_level_r, out_level_nxt;
  logic                         out_no_split_r, out_no_split_nxt;

  logic                         in_acc;
  logic                         out_free;
  logic                         load_room;
  logic                         skip_split;
  logic                         sweep_end;
  logic [otsu_pkg::BIN_W-1:0]   h_in;

  logic                         ram_we;
  logic [otsu_pkg::ADDR_W-1:0]  ram_waddr;
  logic [otsu_pkg::ADDR_W-1:0]  ram_raddr;
  logic [otsu_pkg::BIN_W-1:0]   ram_rdata;

  otsu_pkg::otsu_mul_req_t      mul0_req, mul1_req;
  otsu_pkg::otsu_mul_rsp_t      mul0_rsp, mul1_rsp;

  // Bin store
  otsu_ram #(
    .WIDTH (otsu_pkg::BIN_W),
    .DEPTH (otsu_pkg::NUM_BINS)
  ) u_bin_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (h_in),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Score multipliers: mul0 forms d*d then d*d*best_den, mul1 best_d2*den
  otsu_mul u_mul0 (.clk(clk), .rst_n(rst_n), .req(mul0_req), .rsp(mul0_rsp));
  otsu_mul u_mul1 (.clk(clk), .rst_n(rst_n), .req(mul1_req), .rsp(mul1_rsp));

  // Handshake and status terms
  assign in_acc     = in_ch.valid && in_ch.ready;
  assign out_free   = !out_valid_r || out_ch.ready;
  assign load_room  = (load_idx_r < otsu_pkg::IDX_W'(otsu_pkg::NUM_BINS));
  assign h_in       = in_ch.bin_count & otsu_pkg::BIN_MASK;
  assign skip_split = (run_pix_r == '0) || (run_pix_r >= tot_pix_r);
  assign sweep_end  = ((sweep_idx_r + otsu_pkg::IDX_W'(1)) == load_idx_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      otsu_pkg::ST_LOAD:     if (in_acc && in_ch.last_bin) state_nxt = otsu_pkg::ST_RD;
      otsu_pkg::ST_RD:       state_nxt = otsu_pkg::ST_ACC;
      otsu_pkg::ST_ACC:      state_nxt = otsu_pkg::ST_PROD;
      otsu_pkg::ST_PROD:     state_nxt = skip_split ? otsu_pkg::ST_NEXT : otsu_pkg::ST_DIFF;
      otsu_pkg::ST_DIFF:     state_nxt = otsu_pkg::ST_SQ_GO;
      otsu_pkg::ST_SQ_GO:    state_nxt = otsu_pkg::ST_SQ_WAIT;
      otsu_pkg::ST_SQ_WAIT: begin
        if (!mul0_rsp.busy && !mul1_rsp.busy) state_nxt = otsu_pkg::ST_LHS_GO;
      end
      otsu_pkg::ST_LHS_GO:   state_nxt = otsu_pkg::ST_LHS_WAIT;
      otsu_pkg::ST_LHS_WAIT: if (!mul0_rsp.busy) state_nxt = otsu_pkg::ST_CMP;
      otsu_pkg::ST_CMP:      state_nxt = otsu_pkg::ST_NEXT;
      otsu_pkg::ST_NEXT:     state_nxt = sweep_end ? otsu_pkg::ST_DONE : otsu_pkg::ST_RD;
      otsu_pkg::ST_DONE:     if (out_free) state_nxt = otsu_pkg::ST_LOAD;
      default:               state_nxt = otsu_pkg::ST_LOAD;
    endcase
  end

  // Control outputs per state
  always_comb begin
    ram_we         = 1'b0;
    ram_waddr      = load_idx_r[otsu_pkg::ADDR_W-1:0];
    ram_raddr      = sweep_idx_r[otsu_pkg::ADDR_W-1:0];
    mul0_req.start = 1'b0;
    mul0_req.x     = otsu_pkg::MUL_X_W'(d_r);
    mul0_req.y     = d_r;
    mul1_req.start = 1'b0;
    mul1_req.x     = best_d2_r;
    mul1_req.y     = otsu_pkg::MUL_Y_W'(den_r);
    case (state_r)
      otsu_pkg::ST_LOAD:   ram_we = in_acc && load_room;
      otsu_pkg::ST_SQ_GO: begin
        mul0_req.start = 1'b1;
        mul1_req.start = 1'b1;
      end
      otsu_pkg::ST_LHS_GO: begin
        mul0_req.start = 1'b1;
        mul0_req.x     = d2_r;
        mul0_req.y     = otsu_pkg::MUL_Y_W'(best_den_r);
      end
      default: begin
      end
    endcase
  end

  // Datapath next values
  always_comb begin
    load_idx_nxt     = load_idx_r;
    sweep_idx_nxt    = sweep_idx_r;
    tot_pix_nxt      = tot_pix_r;
    tot_wsum_nxt     = tot_wsum_r;
    run_pix_nxt      = run_pix_r;
    run_wsum_nxt     = run_wsum_r;
    a_nxt            = a_r;
    b_nxt            = b_r;
    rem_pix_nxt      = rem_pix_r;
    d_nxt            = d_r;
    den_nxt          = den_r;
    d2_nxt           = d2_r;
    rhs_nxt          = rhs_r;
    best_d2_nxt      = best_d2_r;
    best_den_nxt     = best_den_r;
    best_level_nxt   = best_level_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_level_nxt    = out_level_r;
    out_no_split_nxt = out_no_split_r;
    case (state_r)
      otsu_pkg::ST_LOAD: begin
        if (in_acc && load_room) begin
          load_idx_nxt = load_idx_r + otsu_pkg::IDX_W'(1);
          tot_pix_nxt  = tot_pix_r + otsu_pkg::PIX_W'(h_in);
          tot_wsum_nxt = tot_wsum_r
                       + otsu_pkg::WSUM_W'(load_idx_r[otsu_pkg::ADDR_W-1:0])
                       * otsu_pkg::WSUM_W'(h_in);
        end
        if (in_acc && in_ch.last_bin) begin
          sweep_idx_nxt = '0;
          run_pix_nxt   = '0;
          run_wsum_nxt  = '0;
        end
      end
      // Running sums up to the current level
      otsu_pkg::ST_ACC: begin
        run_pix_nxt  = run_pix_r + otsu_pkg::PIX_W'(ram_rdata);
        run_wsum_nxt = run_wsum_r
                     + otsu_pkg::WSUM_W'(sweep_idx_r[otsu_pkg::ADDR_W-1:0])
                     * otsu_pkg::WSUM_W'(ram_rdata);
      end
      // N*S, T*w and N-w
      otsu_pkg::ST_PROD: begin
        a_nxt       = tot_pix_r * run_wsum_r;
        b_nxt       = tot_wsum_r * run_pix_r;
        rem_pix_nxt = tot_pix_r - run_pix_r;
      end
      // |d| and w*(N-w)
      otsu_pkg::ST_DIFF: begin
        d_nxt   = (a_r >= b_r) ? (a_r - b_r) : (b_r - a_r);
        den_nxt = run_pix_r * rem_pix_r;
      end
      otsu_pkg::ST_SQ_WAIT: begin
        d2_nxt  = mul0_rsp.product[otsu_pkg::SQ_W-1:0];
        rhs_nxt = mul1_rsp.product;
      end
      // Strictly better keeps the lower level on ties
      otsu_pkg::ST_CMP: begin
        if (mul0_rsp.product > rhs_r) begin
          best_d2_nxt    = d2_r;
          best_den_nxt   = den_r;
          best_level_nxt = sweep_idx_r[otsu_pkg::ADDR_W-1:0];
        end
      end
      otsu_pkg::ST_NEXT: sweep_idx_nxt = sweep_idx_r + otsu_pkg::IDX_W'(1);
      // Publish result and rearm for the next histogram
      otsu_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_no_split_nxt = (best_d2_r == '0);
          out_level_nxt    = (best_d2_r == '0) ? '0
                                               : otsu_pkg::LEVEL_W'(best_level_r);
          load_idx_nxt     = '0;
          tot_pix_nxt      = '0;
          tot_wsum_nxt     = '0;
          best_d2_nxt      = '0;
          best_den_nxt     = otsu_pkg::DEN_W'(1);
          best_level_nxt   = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= otsu_pkg::ST_LOAD;
      load_idx_r   <= '0;
      sweep_idx_r  <= '0;
      tot_pix_r    <= '0;
      tot_wsum_r   <= '0;
      run_pix_r    <= '0;
      run_wsum_r   <= '0;
      best_d2_r    <= '0;
      best_den_r   <= otsu_pkg::DEN_W'(1);
      best_level_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      load_idx_r   <= load_idx_nxt;
      sweep_idx_r  <= sweep_idx_nxt;
      tot_pix_r    <= tot_pix_nxt;
      tot_wsum_r   <= tot_wsum_nxt;
      run_pix_r    <= run_pix_nxt;
      run_wsum_r   <= run_wsum_nxt;
      best_d2_r    <= best_d2_nxt;
      best_den_r   <= best_den_nxt;
      best_level_r <= best_level_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    a_r            <= a_nxt;
    b_r            <= b_nxt;
    rem_pix_r      <= rem_pix_nxt;
    d_r            <= d_nxt;
    den_r          <= den_nxt;
    d2_r           <= d2_nxt;
    rhs_r          <= rhs_nxt;
    out_level_r    <= out_level_nxt;
    out_no_split_r <= out_no_split_nxt;
  end

  // Channel outputs
  assign in_ch.ready            = (state_r == otsu_pkg::ST_LOAD);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.threshold_level = out_level_r;
  assign out_ch.no_split        = out_no_split_r;

endmodule

`default_nettype wire

### hdl/otsu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module otsu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hdl/otsu_mul.sv
// Digit-serial multiplier: one DIGIT_W-bit digit of y per cycle, MSB digit first.
`default_nettype none

module otsu_mul (
  input  logic                    clk,
  input  logic                    rst_n,
  input  otsu_pkg::otsu_mul_req_t req,
  output otsu_pkg::otsu_mul_rsp_t rsp
);

  logic                           busy_r, busy_nxt;
  logic [otsu_pkg::MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [otsu_pkg::MUL_X_W-1:0]   x_r, x_nxt;
  logic [otsu_pkg::MUL_Y_W-1:0]   y_r, y_nxt;
  logic [otsu_pkg::PROD_W-1:0]    acc_r, acc_nxt;
  logic [otsu_pkg::MUL_X_W+otsu_pkg::DIGIT_W-1:0] pp;

  // Partial product of x and the current top digit of y
  assign pp = x_r * y_r[otsu_pkg::MUL_Y_W-1 -: otsu_pkg::DIGIT_W];

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = otsu_pkg::MUL_CNT_W'(otsu_pkg::MUL_DIGITS);
      x_nxt    = req.x;
      y_nxt    = req.y;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt  = (acc_r << otsu_pkg::DIGIT_W) + otsu_pkg::PROD_W'(pp);
      y_nxt    = y_r << otsu_pkg::DIGIT_W;
      cnt_nxt  = cnt_r - otsu_pkg::MUL_CNT_W'(1);
      busy_nxt = (cnt_r != otsu_pkg::MUL_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
  end

  assign rsp.busy    = busy_r;
  assign rsp.product = acc_r;

endmodule

`default_nettype wire

### hdl/otsu_chk.sv
// Port-level checker for the Otsu threshold unit, bound to the top level.
`default_nettype none

module otsu_chk (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         in_last_bin,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [otsu_pkg::LEVEL_W-1:0] out_threshold_level,
  input wire logic                         out_no_split
);

  // A stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_threshold_level)
                                && $stable(out_no_split))
    else $error("result changed while stalled");

  // No split always reports level zero
  a_no_split_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_split |-> out_threshold_level == '0)
    else $error("no_split with nonzero level");

  // The last bin starts the sweep, which blocks further bins
  a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_bin |=> !in_ready)
    else $error("bin accepted right after last bin");

  // Reset leaves the unit empty and ready for bins
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("bad state after reset");

  // A new result only comes out of a sweep
  a_result_from_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a sweep");

endmodule

bind otsu_threshold_from_histogram_unit otsu_chk u_otsu_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .in_last_bin         (in_ch.last_bin),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_threshold_level (out_ch.threshold_level),
  .out_no_split        (out_ch.no_split)
);

`default_nettype wire

### tb/otsu_threshold_checker.sv
`timescale 1ns / 1ps
// Checker: rebuilds each histogram from the bin channel, predicts its threshold, checks results.
module otsu_threshold_checker (
  input  logic clk,
  input  logic rst_n,
  otsu_in_if   bin_mon,
  otsu_out_if  res_mon,
  output int   fail_count,
  output int   pending_count,
  output int   results_checked,
  output int   no_split_count
);

  typedef struct packed {
    logic [otsu_pkg::LEVEL_W-1:0] level;
    logic                         no_split;
  } threshold_t;

  // Shadow copy of the histogram being loaded
  logic [otsu_pkg::BIN_W-1:0]  bin_mem [otsu_pkg::NUM_BINS];
  logic [otsu_pkg::IDX_W-1:0]  bins_loaded;
  logic [otsu_pkg::PIX_W-1:0]  pix_total;
  logic [otsu_pkg::WSUM_W-1:0] wsum_total;

  threshold_t expected_thresholds[$];

  // Sweep the stored bins; score each split by d^2 / (w*(N-w)) via cross-multiplication
  function automatic threshold_t otsu_best_split();
    logic [otsu_pkg::PIX_W-1:0]  w;
    logic [otsu_pkg::WSUM_W-1:0] s;
    logic [otsu_pkg::DIFF_W-1:0] a;
    logic [otsu_pkg::DIFF_W-1:0] b;
    logic [otsu_pkg::DIFF_W-1:0] d;
    logic [otsu_pkg::DIFF_W-1:0] best_d;
    logic [otsu_pkg::DEN_W-1:0]  den;
    logic [otsu_pkg::DEN_W-1:0]  best_den;
    logic [7:0]                  best_lvl;
    logic [191:0]                lhs;
    logic [191:0]                rhs;
    threshold_t                  res;
    w        = '0;
    s        = '0;
    best_d   = '0;
    best_den = otsu_pkg::DEN_W'(1);
    best_lvl = '0;
    for (int lvl = 0; lvl < int'(bins_loaded); lvl++) begin
      w = w + otsu_pkg::PIX_W'(bin_mem[lvl]);
      s = s + otsu_pkg::WSUM_W'(32'(lvl) * 32'(bin_mem[lvl]));
      // empty class on either side: no score
      if (w != '0 && w < pix_total) begin
        a   = otsu_pkg::DIFF_W'(pix_total) * otsu_pkg::DIFF_W'(s);
        b   = otsu_pkg::DIFF_W'(wsum_total) * otsu_pkg::DIFF_W'(w);
        d   = (a >= b) ? (a - b) : (b - a);
        den = otsu_pkg::DEN_W'(w) * otsu_pkg::DEN_W'(pix_total - w);
        lhs = 192'(d) * 192'(d) * 192'(best_den);
        rhs = 192'(best_d) * 192'(best_d) * 192'(den);
        // strictly better only, so ties keep the lower level
        if (lhs > rhs) begin
          best_d   = d;
          best_den = den;
          best_lvl = lvl[7:0];
        end
      end
    end
    if (best_d == '0) begin
      res.level    = '0;
      res.no_split = 1'b1;
    end else begin
      res.level    = otsu_pkg::LEVEL_W'(best_lvl);
      res.no_split = 1'b0;
    end
    return res;
  endfunction

  // Store one bin; the last one closes the histogram and queues its threshold
  task automatic absorb_bin(input logic [otsu_pkg::BIN_W-1:0] count, input logic last);
    logic [otsu_pkg::BIN_W-1:0] kept;
    kept = count & otsu_pkg::BIN_MASK;
    // bins past the store depth are dropped
    if (int'(bins_loaded) < otsu_pkg::NUM_BINS) begin
      bin_mem[bins_loaded[otsu_pkg::ADDR_W-1:0]] = kept;
      pix_total   = pix_total + otsu_pkg::PIX_W'(kept);
      wsum_total  = wsum_total + otsu_pkg::WSUM_W'(32'(bins_loaded) * 32'(kept));
      bins_loaded = bins_loaded + otsu_pkg::IDX_W'(1);
    end
    if (last) begin
      expected_thresholds.push_back(otsu_best_split());
      bins_loaded = '0;
      pix_total   = '0;
      wsum_total  = '0;
    end
  endtask

  // Monitor both channels at the rising edge
  always @(posedge clk) begin
    threshold_t exp_res;
    if (!rst_n) begin
      bins_loaded     = '0;
      pix_total       = '0;
      wsum_total      = '0;
      fail_count      = 0;
      results_checked = 0;
      no_split_count  = 0;
      expected_thresholds.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        results_checked++;
        if (expected_thresholds.size() == 0) begin
          $display("%0t: unexpected result transaction: level %0d no_split %0b", $time,
                   res_mon.threshold_level, res_mon.no_split);
          fail_count++;
        end else begin
          exp_res = expected_thresholds.pop_front();
          if (res_mon.threshold_level !== exp_res.level) begin
            $display("%0t: threshold_level mismatch: expected %0d, actual %0d", $time,
                     exp_res.level, res_mon.threshold_level);
            fail_count++;
          end
          if (res_mon.no_split !== exp_res.no_split) begin
            $display("%0t: no_split mismatch: expected %0b, actual %0b", $time,
                     exp_res.no_split, res_mon.no_split);
            fail_count++;
          end
          if (exp_res.no_split) no_split_count++;
        end
      end
      if (bin_mon.valid && bin_mon.ready) begin
        absorb_bin(bin_mon.bin_count, bin_mon.last_bin);
      end
    end
    pending_count = expected_thresholds.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, histogram stimulus, receiver pacing and the verdict.
module tb;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int BIN_TARGET   = 1150;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n;

  int src_idle_pct;
  int rx_idle_pct;
  int hold_requests;
  int cycle_count = 0;
  int bins_stored;
  int bins_dropped;
  int histograms_sent;

  int fail_count;
  int pending_count;
  int results_checked;
  int no_split_count;

  otsu_in_if  in_ch ();
  otsu_out_if out_ch ();

  otsu_threshold_from_histogram_unit i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  otsu_threshold_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .bin_mon        (in_ch),
    .res_mon        (out_ch),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .results_checked(results_checked),
    .no_split_count (no_split_count)
  );

  always #6 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int hold_left;
    int holds_seen;
    hold_left    = 0;
    holds_seen   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Bin values: zeros, extremes, single bits, small and full-range counts
  function automatic logic [otsu_pkg::BIN_W-1:0] random_count();
    case ($urandom_range(9))
      0, 1:    return '0;
      2:       return '1;
      3:       return otsu_pkg::BIN_W'(1) << $urandom_range(otsu_pkg::BIN_W - 1);
      4, 5:    return otsu_pkg::BIN_W'($urandom_range(15));
      default: return otsu_pkg::BIN_W'($urandom);
    endcase
  endfunction

  // One bin transaction; called and returns at a falling edge, valid stays high
  task automatic send_bin(input logic [otsu_pkg::BIN_W-1:0] count, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.bin_count <= count;
    in_ch.last_bin  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_list(input logic [otsu_pkg::BIN_W-1:0] counts[$]);
    for (int k = 0; k < counts.size(); k++) begin
      send_bin(counts[k], k == counts.size() - 1);
      bins_stored++;
    end
    histograms_sent++;
  endtask

  task automatic send_histogram(input int len, input bit saturate);
    logic [otsu_pkg::BIN_W-1:0] count;
    for (int k = 0; k < len; k++) begin
      count = saturate ? '1 : random_count();
      send_bin(count, k == len - 1);
      if (k < otsu_pkg::NUM_BINS) bins_stored++;
      else bins_dropped++;
    end
    histograms_sent++;
  endtask

  // Stimulus and verdict
  initial begin
    logic [otsu_pkg::BIN_W-1:0] dir_bins[$];
    int                         len;
    int                         pick;
    in_ch.valid     = 1'b0;
    in_ch.bin_count = '0;
    in_ch.last_bin  = 1'b0;
    rst_n           = 1'b0;
    src_idle_pct    = 11;
    rx_idle_pct     = 81;
    hold_requests   = 0;
    bins_stored     = 0;
    bins_dropped    = 0;
    histograms_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: one bin, all zeros, full counts, ties, bit patterns, single populated level
    dir_bins = '{16'd5};
    send_list(dir_bins);
    dir_bins = '{16'd0, 16'd0, 16'd0};
    send_list(dir_bins);
    dir_bins = '{16'hFFFF, 16'hFFFF};
    send_list(dir_bins);
    dir_bins = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
    send_list(dir_bins);
    dir_bins = '{16'd10, 16'd0, 16'd10};
    send_list(dir_bins);
    dir_bins = '{16'hAAAA, 16'h5555, 16'h0001, 16'h8000};
    send_list(dir_bins);
    dir_bins = '{16'd0, 16'd0, 16'd7, 16'd0, 16'd0};
    send_list(dir_bins);

    // Receiver holds off while short histograms keep coming: output fills, input stalls
    hold_requests++;
    repeat (3) send_histogram(6, 1'b0);

    // Random histograms over three pacing phases
    while (bins_stored < BIN_TARGET) begin
      if (bins_stored >= 800) begin
        src_idle_pct = 0;
        rx_idle_pct  = 0;
      end else if (bins_stored >= 420) begin
        src_idle_pct = 81;
        rx_idle_pct  = 11;
      end
      if (histograms_sent == 12) begin
        // full store, every bin at its maximum
        send_histogram(otsu_pkg::NUM_BINS, 1'b1);
      end else if (histograms_sent == 30) begin
        // overlong: bins beyond the store are dropped
        send_histogram(otsu_pkg::NUM_BINS + $urandom_range(40, 1), 1'b0);
      end else begin
        pick = $urandom_range(99);
        if (pick < 2) len = $urandom_range(otsu_pkg::NUM_BINS, 100);
        else if (pick < 15) len = $urandom_range(64, 17);
        else len = $urandom_range(16, 1);
        send_histogram(len, 1'b0);
      end
    end
    in_ch.valid <= 1'b0;

    // Drain
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d histograms: %0d bins stored, %0d bins beyond the store dropped.",
             histograms_sent, bins_stored, bins_dropped);
    $display("%0d thresholds compared, %0d of them with no usable split.",
             results_checked, no_split_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
